// File: design/lsmu_pkg.sv
package lsmu_pkg;

  localparam int unsigned ADDR_BITS = 16;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_BITS;

  typedef enum logic [3:0] {
    KIND_MOV  = 4'd0,
    KIND_MVI  = 4'd1,
    KIND_LDA  = 4'd2,
    KIND_STA  = 4'd3,
    KIND_LHLD = 4'd4,
    KIND_SHLD = 4'd5,
    KIND_STAX = 4'd6,
    KIND_XCHG = 4'd7,
    KIND_SPHL = 4'd8,
    KIND_XTHL = 4'd9,
    KIND_PUSH = 4'd10,
    KIND_POP  = 4'd11
  } kind_e;

  localparam logic [2:0] OPD_B = 3'd0;
  localparam logic [2:0] OPD_C = 3'd1;
  localparam logic [2:0] OPD_D = 3'd2;
  localparam logic [2:0] OPD_E = 3'd3;
  localparam logic [2:0] OPD_H = 3'd4;
  localparam logic [2:0] OPD_L = 3'd5;
  localparam logic [2:0] OPD_M = 3'd6;
  localparam logic [2:0] OPD_A = 3'd7;

  localparam logic [2:0] PAIR_HL = 3'd2;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  first_operand;
    logic [2:0]  second_operand;
    logic [15:0] immediate;
  } lsmu_req_t;

  typedef struct packed {
    logic [7:0]  reg_a;
    logic [7:0]  reg_b;
    logic [7:0]  reg_c;
    logic [7:0]  reg_d;
    logic [7:0]  reg_e;
    logic [7:0]  reg_h;
    logic [7:0]  reg_l;
    logic [15:0] stack_pointer;
    logic        error;
  } lsmu_rsp_t;

endpackage

// File: design/lsmu_ram.sv
module lsmu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

// File: design/cpu_load_store_move_unit_core.sv
// Channel  | Ports                  | Handshake
// ---------+------------------------+------------------------------------------
// request  | req_i                  | taken at a clock edge with start && !busy
// result   | result_o               | valid for the one cycle done_o is high
//
// An instruction runs in ST_RUN with at most one data memory access per step.
// XTHL has the most steps: two reads and two writes through the single port
// of the data memory.
// After reset the data memory is zeroed, one byte a cycle, over all 2^ADDR_BITS
// addresses; busy stays high throughout. The result cannot be stalled.
module cpu_load_store_move_unit_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  lsmu_pkg::lsmu_req_t  req_i,
  output logic                 done_o,
  output lsmu_pkg::lsmu_rsp_t  result_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q;
  logic [1:0] step_q;
  logic done_q;
  logic err_q;
  logic [lsmu_pkg::ADDR_BITS-1:0] clr_cnt_q;

  lsmu_pkg::kind_e kind_q;
  logic [2:0] op1_q, op2_q;
  logic [15:0] imm_q;

  logic [7:0] a_q, b_q, c_q, d_q, e_q, h_q, l_q;
  logic [15:0] sp_q;

  logic accept;
  logic err_d;
  logic pair_bad;

  logic mem_en, mem_we;
  logic [15:0] mem_addr;
  logic [7:0] mem_wdata, mem_rdata;

  logic rf_we;
  logic [2:0] rf_sel;
  logic [7:0] rf_wdata;
  logic sp_we;
  logic [15:0] sp_wdata;
  logic xchg;
  logic last;

  logic [2:0] hi_code, lo_code;
  logic [15:0] hl;

  function automatic logic [7:0] rd_reg(
    input logic [2:0] code,
    input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
    input logic [7:0] d, input logic [7:0] e, input logic [7:0] h,
    input logic [7:0] l
  );
    logic [7:0] v;
    case (code)
      lsmu_pkg::OPD_B: v = b;
      lsmu_pkg::OPD_C: v = c;
      lsmu_pkg::OPD_D: v = d;
      lsmu_pkg::OPD_E: v = e;
      lsmu_pkg::OPD_H: v = h;
      lsmu_pkg::OPD_L: v = l;
      lsmu_pkg::OPD_A: v = a;
      default:         v = 8'd0;
    endcase
    return v;
  endfunction

  assign accept  = start && !busy;
  assign busy    = (state_q != ST_IDLE);
  assign hi_code = {op1_q[1:0], 1'b0};
  assign lo_code = {op1_q[1:0], 1'b1};
  assign hl      = {h_q, l_q};

  always_comb begin
    pair_bad = (req_i.first_operand > lsmu_pkg::PAIR_HL);
    err_d    = 1'b0;
    case (req_i.kind)
      lsmu_pkg::KIND_MOV:  err_d = (req_i.first_operand == lsmu_pkg::OPD_M) &&
                                   (req_i.second_operand == lsmu_pkg::OPD_M);
      lsmu_pkg::KIND_MVI:  err_d = (req_i.first_operand == lsmu_pkg::OPD_M);
      lsmu_pkg::KIND_STAX, lsmu_pkg::KIND_PUSH, lsmu_pkg::KIND_POP: err_d = pair_bad;
      lsmu_pkg::KIND_LDA, lsmu_pkg::KIND_STA, lsmu_pkg::KIND_LHLD, lsmu_pkg::KIND_SHLD,
      lsmu_pkg::KIND_XCHG, lsmu_pkg::KIND_SPHL, lsmu_pkg::KIND_XTHL: err_d = 1'b0;
      default:             err_d = 1'b1;
    endcase
  end

  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = 16'd0;
    mem_wdata = 8'd0;
    rf_we     = 1'b0;
    rf_sel    = lsmu_pkg::OPD_A;
    rf_wdata  = mem_rdata;
    sp_we     = 1'b0;
    sp_wdata  = sp_q;
    xchg      = 1'b0;
    last      = 1'b1;
    if (state_q == ST_CLEAR) begin
      mem_en   = 1'b1;
      mem_we   = 1'b1;
      mem_addr = 16'(clr_cnt_q);
    end else if (state_q == ST_RUN && !err_q) begin
      case (kind_q)
        lsmu_pkg::KIND_MOV: begin
          if (op1_q == lsmu_pkg::OPD_M) begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = hl;
            mem_wdata = rd_reg(op2_q, a_q, b_q, c_q, d_q, e_q, h_q, l_q);
          end else if (op2_q == lsmu_pkg::OPD_M) begin
            if (step_q == 2'd0) begin
              mem_en   = 1'b1;
              mem_addr = hl;
              last     = 1'b0;
            end else begin
              rf_we  = 1'b1;
              rf_sel = op1_q;
            end
          end else begin
            rf_we    = 1'b1;
            rf_sel   = op1_q;
            rf_wdata = rd_reg(op2_q, a_q, b_q, c_q, d_q, e_q, h_q, l_q);
          end
        end
        lsmu_pkg::KIND_MVI: begin
          rf_we    = 1'b1;
          rf_sel   = op1_q;
          rf_wdata = imm_q[7:0];
        end
        lsmu_pkg::KIND_LDA: begin
          if (step_q == 2'd0) begin
            mem_en   = 1'b1;
            mem_addr = imm_q;
            last     = 1'b0;
          end else begin
            rf_we = 1'b1;
          end
        end
        lsmu_pkg::KIND_STA: begin
          mem_en    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = imm_q;
          mem_wdata = a_q;
        end
        lsmu_pkg::KIND_LHLD: begin
          case (step_q)
            2'd0: begin
              mem_en   = 1'b1;
              mem_addr = imm_q;
              last     = 1'b0;
            end
            2'd1: begin
              rf_we    = 1'b1;
              rf_sel   = lsmu_pkg::OPD_L;
              mem_en   = 1'b1;
              mem_addr = imm_q + 16'd1;
              last     = 1'b0;
            end
            default: begin
              rf_we  = 1'b1;
              rf_sel = lsmu_pkg::OPD_H;
            end
          endcase
        end
        lsmu_pkg::KIND_SHLD: begin
          mem_en = 1'b1;
          mem_we = 1'b1;
          if (step_q == 2'd0) begin
            mem_addr  = imm_q;
            mem_wdata = l_q;
            last      = 1'b0;
          end else begin
            mem_addr  = imm_q + 16'd1;
            mem_wdata = h_q;
          end
        end
        lsmu_pkg::KIND_STAX: begin
          mem_en    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = {rd_reg(hi_code, a_q, b_q, c_q, d_q, e_q, h_q, l_q),
                       rd_reg(lo_code, a_q, b_q, c_q, d_q, e_q, h_q, l_q)};
          mem_wdata = a_q;
        end
        lsmu_pkg::KIND_XCHG: xchg = 1'b1;
        lsmu_pkg::KIND_SPHL: begin
          sp_we    = 1'b1;
          sp_wdata = hl;
        end
        lsmu_pkg::KIND_XTHL: begin
          case (step_q)
            2'd0: begin
              mem_en   = 1'b1;
              mem_addr = sp_q;
              last     = 1'b0;
            end
            2'd1: begin
              rf_we     = 1'b1;
              rf_sel    = lsmu_pkg::OPD_L;
              mem_en    = 1'b1;
              mem_we    = 1'b1;
              mem_addr  = sp_q;
              mem_wdata = l_q;
              last      = 1'b0;
            end
            2'd2: begin
              mem_en   = 1'b1;
              mem_addr = sp_q + 16'd1;
              last     = 1'b0;
            end
            default: begin
              rf_we     = 1'b1;
              rf_sel    = lsmu_pkg::OPD_H;
              mem_en    = 1'b1;
              mem_we    = 1'b1;
              mem_addr  = sp_q + 16'd1;
              mem_wdata = h_q;
            end
          endcase
        end
        lsmu_pkg::KIND_PUSH: begin
          mem_en = 1'b1;
          mem_we = 1'b1;
          if (step_q == 2'd0) begin
            mem_addr  = sp_q - 16'd1;
            mem_wdata = rd_reg(hi_code, a_q, b_q, c_q, d_q, e_q, h_q, l_q);
            last      = 1'b0;
          end else begin
            mem_addr  = sp_q - 16'd2;
            mem_wdata = rd_reg(lo_code, a_q, b_q, c_q, d_q, e_q, h_q, l_q);
            sp_we     = 1'b1;
            sp_wdata  = sp_q - 16'd2;
          end
        end
        lsmu_pkg::KIND_POP: begin
          case (step_q)
            2'd0: begin
              mem_en   = 1'b1;
              mem_addr = sp_q;
              last     = 1'b0;
            end
            2'd1: begin
              rf_we    = 1'b1;
              rf_sel   = lo_code;
              mem_en   = 1'b1;
              mem_addr = sp_q + 16'd1;
              last     = 1'b0;
            end
            default: begin
              rf_we    = 1'b1;
              rf_sel   = hi_code;
              sp_we    = 1'b1;
              sp_wdata = sp_q + 16'd2;
            end
          endcase
        end
        default: last = 1'b1;
      endcase
    end
  end

  lsmu_ram #(
    .WIDTH (8),
    .DEPTH (lsmu_pkg::MEM_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr[lsmu_pkg::ADDR_BITS-1:0]),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      step_q    <= 2'd0;
      done_q    <= 1'b0;
      err_q     <= 1'b0;
      clr_cnt_q <= '0;
      kind_q    <= lsmu_pkg::KIND_MOV;
      a_q       <= 8'd0;
      b_q       <= 8'd0;
      c_q       <= 8'd0;
      d_q       <= 8'd0;
      e_q       <= 8'd0;
      h_q       <= 8'd0;
      l_q       <= 8'd0;
      sp_q      <= 16'd0;
    end else begin
      done_q <= (state_q == ST_RUN) && last;
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (&clr_cnt_q) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            kind_q  <= lsmu_pkg::kind_e'(req_i.kind);
            err_q   <= err_d;
            step_q  <= 2'd0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          step_q <= step_q + 2'd1;
          if (last) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (rf_we) begin
        case (rf_sel)
          lsmu_pkg::OPD_B: b_q <= rf_wdata;
          lsmu_pkg::OPD_C: c_q <= rf_wdata;
          lsmu_pkg::OPD_D: d_q <= rf_wdata;
          lsmu_pkg::OPD_E: e_q <= rf_wdata;
          lsmu_pkg::OPD_H: h_q <= rf_wdata;
          lsmu_pkg::OPD_L: l_q <= rf_wdata;
          lsmu_pkg::OPD_A: a_q <= rf_wdata;
          default:         a_q <= a_q;
        endcase
      end
      if (xchg) begin
        d_q <= h_q;
        h_q <= d_q;
        e_q <= l_q;
        l_q <= e_q;
      end
      if (sp_we) begin
        sp_q <= sp_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op1_q <= req_i.first_operand;
      op2_q <= req_i.second_operand;
      imm_q <= req_i.immediate;
    end
  end

  assign done_o                 = done_q;
  assign result_o.reg_a         = a_q;
  assign result_o.reg_b         = b_q;
  assign result_o.reg_c         = c_q;
  assign result_o.reg_d         = d_q;
  assign result_o.reg_e         = e_q;
  assign result_o.reg_h         = h_q;
  assign result_o.reg_l         = l_q;
  assign result_o.stack_pointer = sp_q;
  assign result_o.error         = err_q;

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still running");

  a_accept_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RUN) && (step_q == 2'd0))
    else $error("accepted transaction did not start at its first step");

  a_err_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.error && $past(state_q == ST_RUN)) |->
      ($stable(sp_q) && $stable(a_q) && $stable(h_q) && $stable(l_q)))
    else $error("rejected transaction changed state");

  a_step_four: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && step_q == 2'd3) |-> (kind_q == lsmu_pkg::KIND_XTHL))
    else $error("fourth step outside exchange with stack top");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_en)
    else $error("memory access while idle");
`endif

endmodule
